### hw/rtl/priority_bitmap_event_scheduler_top_macros.svh
// Assertion macros shared by the scheduler RTL.
`ifndef PRIORITY_BITMAP_EVENT_SCHEDULER_TOP_MACROS_SVH
`define PRIORITY_BITMAP_EVENT_SCHEDULER_TOP_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define PBES_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scheduler assertion failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define PBES_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scheduler assertion failed");

`endif

### hw/rtl/pbes_pkg.sv
// Types, constants and helper functions for the priority bitmap event scheduler.
package pbes_pkg;

    localparam int PRIO_W          = 5;
    localparam int EVT_W           = 16;
    localparam int MASK_W          = 32;
    localparam int NUM_LEVELS_DEF  = 32;
    localparam int QUEUE_DEPTH_DEF = 8;
    localparam int EVENT_WIDTH_DEF = 16;

    typedef enum logic [1:0] {
        OP_POST       = 2'd0,
        OP_POST_AHEAD = 2'd1,
        OP_FETCH      = 2'd2,
        OP_FLUSH      = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_UNREG = 2'd3
    } status_t;

    typedef struct packed {
        op_t               operation;
        logic [PRIO_W-1:0] priority_req;
        logic [EVT_W-1:0]  event_id;
    } cmd_t;

    typedef struct packed {
        status_t           status;
        logic [PRIO_W-1:0] served_priority;
        logic [EVT_W-1:0]  event_out;
        logic              level_drained;
        logic              any_ready;
    } result_t;

    // Outcome of one executed transaction, apart from the dequeued event itself.
    typedef struct packed {
        status_t           status;
        logic [PRIO_W-1:0] served_priority;
        logic              level_drained;
        logic              any_ready;
        logic              fetched;
    } exec_info_t;

    // Only levels below the enable mask width can ever be registered.
    function automatic int levels_used(int num_levels);
        return (num_levels < MASK_W) ? num_levels : MASK_W;
    endfunction

    // Stored event bits: the handle field never carries more than EVT_W bits.
    function automatic int store_width(int event_width);
        return (event_width < EVT_W) ? event_width : EVT_W;
    endfunction

endpackage

### hw/rtl/pbes_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pbes_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/pbes_prio_enc.sv
// Priority encoder that returns the index of the highest set bit.
module pbes_prio_enc #(
    parameter int WIDTH = 32
) (
    input  logic [WIDTH-1:0]         bits,
    output logic                     found,
    output logic [$clog2(WIDTH)-1:0] index
);

    localparam int IDX_W = $clog2(WIDTH);

    always_comb
    begin
        index = '0;
        for (int i = 0; i < WIDTH; i++)
        begin
            if (bits[i])
            begin
                index = IDX_W'(i);
            end
        end
    end

    assign found = |bits;

endmodule

### hw/rtl/pbes_queue_ctrl.sv
// Queue bookkeeping: ready bitmap, per-level head and count, and event memory requests.
module pbes_queue_ctrl
    import pbes_pkg::*;
#(
    parameter int NUM_LEVELS  = NUM_LEVELS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int EVENT_WIDTH = EVENT_WIDTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                exec,
    input  cmd_t                cmd,
    input  logic [MASK_W-1:0]   enable_mask,
    output exec_info_t          info,
    output logic                mem_we,
    output logic                mem_re,
    output logic [$clog2(levels_used(NUM_LEVELS) * QUEUE_DEPTH)-1:0] mem_addr,
    output logic [store_width(EVENT_WIDTH)-1:0] mem_wdata
);

    localparam int LEVELS  = levels_used(NUM_LEVELS);
    localparam int LVL_W   = $clog2(LEVELS);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int HEAD_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int SUM_W   = CNT_W + 1;
    localparam int AW      = $clog2(LEVELS * QUEUE_DEPTH);
    localparam int STORE_W = store_width(EVENT_WIDTH);

    logic [LEVELS-1:0] ready_reg;
    logic [LEVELS-1:0] ready_next;
    logic [HEAD_W-1:0] head_reg  [LEVELS];
    logic [HEAD_W-1:0] head_next [LEVELS];
    logic [CNT_W-1:0]  count_reg [LEVELS];
    logic [CNT_W-1:0]  count_next[LEVELS];

    logic              top_found;
    logic [LVL_W-1:0]  top_idx;
    logic [LVL_W-1:0]  sel_idx;
    logic              lvl_registered;
    logic [HEAD_W-1:0] cur_head;
    logic [CNT_W-1:0]  cur_count;
    logic [SUM_W-1:0]  tail_sum;
    logic [HEAD_W-1:0] tail_slot;
    logic [HEAD_W-1:0] head_dec;
    logic [HEAD_W-1:0] head_inc;
    logic [HEAD_W-1:0] slot;
    logic              wr;
    logic              rd;

    pbes_prio_enc #(
        .WIDTH (LEVELS)
    ) u_prio_enc (
        .bits  (ready_reg),
        .found (top_found),
        .index (top_idx)
    );

    assign lvl_registered = ({1'b0, cmd.priority_req} < (PRIO_W + 1)'(LEVELS))
                            && enable_mask[cmd.priority_req];
    assign sel_idx   = (cmd.operation == OP_FETCH) ? top_idx : cmd.priority_req[LVL_W-1:0];
    assign cur_head  = head_reg[sel_idx];
    assign cur_count = count_reg[sel_idx];

    // Tail position wraps at most once, so one compare and subtract suffices.
    assign tail_sum  = SUM_W'(cur_head) + SUM_W'(cur_count);
    assign tail_slot = (tail_sum >= SUM_W'(QUEUE_DEPTH))
                       ? HEAD_W'(tail_sum - SUM_W'(QUEUE_DEPTH))
                       : HEAD_W'(tail_sum);
    assign head_dec  = (cur_head == '0) ? HEAD_W'(QUEUE_DEPTH - 1) : cur_head - 1'b1;
    assign head_inc  = (cur_head == HEAD_W'(QUEUE_DEPTH - 1)) ? '0 : cur_head + 1'b1;

    always_comb
    begin
        ready_next           = ready_reg;
        head_next            = head_reg;
        count_next           = count_reg;
        info.status          = ST_OK;
        info.served_priority = '0;
        info.level_drained   = 1'b0;
        info.fetched         = 1'b0;
        slot                 = cur_head;
        wr                   = 1'b0;
        rd                   = 1'b0;
        case (cmd.operation)
            OP_POST, OP_POST_AHEAD:
            begin
                if (!lvl_registered)
                begin
                    info.status = ST_UNREG;
                end
                else if (cur_count == CNT_W'(QUEUE_DEPTH))
                begin
                    info.status = ST_FULL;
                end
                else
                begin
                    wr = 1'b1;
                    if (cmd.operation == OP_POST)
                    begin
                        slot = tail_slot;
                    end
                    else
                    begin
                        slot               = head_dec;
                        head_next[sel_idx] = head_dec;
                    end
                    count_next[sel_idx] = cur_count + 1'b1;
                    ready_next[sel_idx] = 1'b1;
                end
            end
            OP_FETCH:
            begin
                if (!top_found)
                begin
                    info.status = ST_EMPTY;
                end
                else if (cur_count == '0)
                begin
                    ready_next[sel_idx] = 1'b0;
                    info.status         = ST_EMPTY;
                end
                else
                begin
                    rd                   = 1'b1;
                    slot                 = cur_head;
                    head_next[sel_idx]   = head_inc;
                    count_next[sel_idx]  = cur_count - 1'b1;
                    info.served_priority = PRIO_W'(top_idx);
                    info.fetched         = 1'b1;
                    if (cur_count == CNT_W'(1))
                    begin
                        ready_next[sel_idx] = 1'b0;
                        info.level_drained  = 1'b1;
                    end
                end
            end
            OP_FLUSH:
            begin
                if (!lvl_registered)
                begin
                    info.status = ST_UNREG;
                end
                else
                begin
                    count_next[sel_idx] = '0;
                    head_next[sel_idx]  = '0;
                    ready_next[sel_idx] = 1'b0;
                    info.level_drained  = 1'b1;
                end
            end
            default:
            begin
                info.status = ST_OK;
            end
        endcase
        info.any_ready = |ready_next;
    end

    assign mem_we    = exec && wr;
    assign mem_re    = exec && rd;
    assign mem_addr  = AW'(AW'(sel_idx) * AW'(QUEUE_DEPTH)) + AW'(slot);
    assign mem_wdata = cmd.event_id[STORE_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_reg <= '0;
            for (int i = 0; i < LEVELS; i++)
            begin
                head_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end
        else if (exec)
        begin
            ready_reg <= ready_next;
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

endmodule

### hw/rtl/priority_bitmap_event_scheduler_top.sv
// Flow: an accepted transaction is held in the s1 command register and executes as it advances
// to the s2 result register, which holds its result until taken; a stalled result holds s1 too.
// Throughput: one transaction per cycle while the result is not stalled; the queue state is
// updated in the execute cycle and the event memory's registered read data drives res.event_out.
// Reset clears the ready bitmap, queue heads, counts and enable mask at once.
// The event memory is not cleared; a fetch only reads entries written by a post.
module priority_bitmap_event_scheduler_top
    import pbes_pkg::*;
#(
    parameter int NUM_LEVELS  = NUM_LEVELS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int EVENT_WIDTH = EVENT_WIDTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  cmd_t              cmd,
    output logic              res_valid,
    input  logic              res_stall,
    output result_t           res,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [MASK_W-1:0] cfg_data
);

`include "priority_bitmap_event_scheduler_top_macros.svh"

    localparam int LEVELS  = levels_used(NUM_LEVELS);
    localparam int DEPTH   = LEVELS * QUEUE_DEPTH;
    localparam int AW      = $clog2(DEPTH);
    localparam int STORE_W = store_width(EVENT_WIDTH);

    logic [MASK_W-1:0] mask_reg;
    logic              s1_valid_reg;
    cmd_t              s1_cmd_reg;
    logic              s2_valid_reg;
    exec_info_t        s2_info_reg;
    logic              s1_advance;
    logic              cmd_accept;
    exec_info_t        info;
    logic              mem_we;
    logic              mem_re;
    logic [AW-1:0]     mem_addr;
    logic [STORE_W-1:0] mem_wdata;
    logic [STORE_W-1:0] mem_rdata;

    assign cfg_ready  = 1'b1;
    assign s1_advance = s1_valid_reg && (!s2_valid_reg || !res_stall);
    assign cmd_stall  = s1_valid_reg && !s1_advance;
    assign cmd_accept = cmd_valid && !cmd_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg     <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                mask_reg <= cfg_data;
            end
            if (cmd_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_advance)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (s2_valid_reg && !res_stall)
            begin
                s2_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_accept)
        begin
            s1_cmd_reg <= cmd;
        end
        if (s1_advance)
        begin
            s2_info_reg <= info;
        end
    end

    pbes_queue_ctrl #(
        .NUM_LEVELS  (NUM_LEVELS),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .EVENT_WIDTH (EVENT_WIDTH)
    ) u_queue_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .exec        (s1_advance),
        .cmd         (s1_cmd_reg),
        .enable_mask (mask_reg),
        .info        (info),
        .mem_we      (mem_we),
        .mem_re      (mem_re),
        .mem_addr    (mem_addr),
        .mem_wdata   (mem_wdata)
    );

    // The read data register only loads on a fetch, so it holds while the result stalls.
    pbes_ram #(
        .WIDTH (STORE_W),
        .DEPTH (DEPTH)
    ) u_event_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_addr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_addr),
        .rdata (mem_rdata)
    );

    assign res_valid           = s2_valid_reg;
    assign res.status          = s2_info_reg.status;
    assign res.served_priority = s2_info_reg.served_priority;
    assign res.event_out       = s2_info_reg.fetched ? EVT_W'(mem_rdata) : '0;
    assign res.level_drained   = s2_info_reg.level_drained;
    assign res.any_ready       = s2_info_reg.any_ready;

    `PBES_ASSERT_IMPL(a_empty_fetch_leaves_none, res_valid && res.status == ST_EMPTY, !res.any_ready)
    `PBES_ASSERT_IMPL(a_full_has_no_payload, res_valid && res.status == ST_FULL, !res.level_drained && res.event_out == '0)
    `PBES_ASSERT_IMPL(a_unreg_has_no_payload, res_valid && res.status == ST_UNREG, res.served_priority == '0 && !res.level_drained && res.event_out == '0)
    `PBES_ASSERT_NEXT(a_exec_fills_result, s1_advance, s2_valid_reg)

endmodule
